// ===== rtl/ptpd_pkg.sv =====
// ============================================================================
// ptpd_pkg: shared definitions for the point to polyline distance block
// Default widths, register indexes, queue status and the back end states.
// ============================================================================
package ptpd_pkg;

    // Default coordinate width and number of fraction bits of the projection.
    localparam int COORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 16;

    // Depth of the segment queue between front and back end.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUERY_X         = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUERY_Y         = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEVIATION_LIMIT = 2'd2;

    // Reset value of the deviation limit in millimetres.
    localparam int LIMIT_RESET = 500;

    // Fill state of the segment queue.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Back end sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_DXX,
        S_MUL_DYY,
        S_MUL_WXD,
        S_MUL_WYD,
        S_DOT_SUM,
        S_CLASSIFY,
        S_DIV,
        S_MUL_PX,
        S_MUL_PY,
        S_ERR_Y,
        S_MUL_EXX,
        S_MUL_EYY,
        S_SUM,
        S_SQRT,
        S_EMIT
    } t_back_state;

endpackage

// ===== rtl/point_to_polyline_distance.sv =====
// ============================================================================
// point_to_polyline_distance: distance from a query point to a streamed path
// A vertex word is taken whenever the two-entry segment queue has room. The
// back end handles each segment in turn with its shared multiplier and the
// one-bit-a-cycle divider; the last vertex adds the square root and output.
// Synchronous reset loads the register defaults and clears path and queue.
// ============================================================================
module point_to_polyline_distance #(
    parameter int COORD_BITS = ptpd_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = ptpd_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ptpd_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [COORD_BITS:0]                i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [COORD_BITS-1:0]       i_vertex_x,
    input  logic signed [COORD_BITS-1:0]       i_vertex_y,
    input  logic                               i_last_vertex,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [COORD_BITS:0]                o_distance,
    output logic                               o_deviates
);
    import ptpd_pkg::*;

    localparam int JW = 4 * COORD_BITS + 1;

    logic signed [COORD_BITS-1:0] r_query_x;
    logic signed [COORD_BITS-1:0] r_query_y;
    logic [COORD_BITS:0]          r_limit;

    t_q_status     q_status;
    logic          q_push;
    logic          q_pop;
    logic [JW-1:0] q_in;
    logic [JW-1:0] q_out;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_query_x <= '0;
            r_query_y <= '0;
            r_limit   <= (COORD_BITS + 1)'(LIMIT_RESET);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_QUERY_X:         r_query_x <= i_cfg_data[COORD_BITS-1:0];
                CFG_QUERY_Y:         r_query_y <= i_cfg_data[COORD_BITS-1:0];
                CFG_DEVIATION_LIMIT: r_limit   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front end: vertex words into segment jobs.
    ptpd_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_last_vertex (i_last_vertex),
        .i_q_status    (q_status),
        .o_push        (q_push),
        .o_job         (q_in)
    );

    // Segment queue.
    ptpd_queue #(
        .WIDTH (JW)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_in),
        .i_pop    (q_pop),
        .o_data   (q_out),
        .o_status (q_status)
    );

    // Back end: distance per segment, minimum and square root.
    ptpd_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_job       (q_out),
        .o_pop       (q_pop),
        .i_query_x   (r_query_x),
        .i_query_y   (r_query_y),
        .i_limit     (r_limit),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_distance  (o_distance),
        .o_deviates  (o_deviates)
    );

endmodule

// ===== rtl/ptpd_queue.sv =====
// ============================================================================
// ptpd_queue: segment queue
// A small first-word-fall-through queue that carries segment jobs from the
// front end to the back end.
// ============================================================================
module ptpd_queue #(
    parameter int WIDTH = 97
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_data,
    output ptpd_pkg::t_q_status  o_status
);
    import ptpd_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    // Status and qualified strobes.
    always_comb begin
        o_status.full  = (r_count == CNT_BITS'(QUEUE_DEPTH));
        o_status.empty = (r_count == '0);
        do_push        = i_push && !o_status.full;
        do_pop         = i_pop && !o_status.empty;
        o_data         = r_mem[r_rd_ptr];
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/ptpd_front.sv =====
// ============================================================================
// ptpd_front: vertex front end
// Accepts vertex words, keeps the previous vertex and turns each vertex into
// a segment job, a single point job or nothing.
// ============================================================================
module ptpd_front #(
    parameter int COORD_BITS = ptpd_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [COORD_BITS-1:0] i_vertex_x,
    input  logic signed [COORD_BITS-1:0] i_vertex_y,
    input  logic                        i_last_vertex,
    input  ptpd_pkg::t_q_status         i_q_status,
    output logic                        o_push,
    output logic [4*COORD_BITS:0]       o_job
);
    import ptpd_pkg::*;

    logic [COORD_BITS-1:0] r_prev_x;
    logic [COORD_BITS-1:0] r_prev_y;
    logic                  r_have_prev;
    logic                  accept;

    // A word is taken whenever the queue has room.
    always_comb begin
        o_in_stall = i_q_status.full;
        accept     = i_in_valid && !i_q_status.full;
        o_push     = accept && (r_have_prev || i_last_vertex);
        // A lone last vertex becomes a segment of zero length at that vertex.
        if (r_have_prev) begin
            o_job = {r_prev_x, r_prev_y, i_vertex_x, i_vertex_y, i_last_vertex};
        end else begin
            o_job = {i_vertex_x, i_vertex_y, i_vertex_x, i_vertex_y, i_last_vertex};
        end
    end

    // Previous vertex; the last vertex of a path clears it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_have_prev <= 1'b0;
        end else if (accept) begin
            if (i_last_vertex) begin
                r_prev_x    <= '0;
                r_prev_y    <= '0;
                r_have_prev <= 1'b0;
            end else begin
                r_prev_x    <= i_vertex_x;
                r_prev_y    <= i_vertex_y;
                r_have_prev <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/ptpd_back.sv =====
// ============================================================================
// ptpd_back: segment back end
// Sequencer around one shared multiplier, a restoring divider for the
// projection parameter, a running minimum and a bit-serial square root.
// ============================================================================
module ptpd_back #(
    parameter int COORD_BITS = ptpd_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = ptpd_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ptpd_pkg::t_q_status          i_q_status,
    input  logic [4*COORD_BITS:0]        i_job,
    output logic                         o_pop,
    input  logic signed [COORD_BITS-1:0] i_query_x,
    input  logic signed [COORD_BITS-1:0] i_query_y,
    input  logic [COORD_BITS:0]          i_limit,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [COORD_BITS:0]          o_distance,
    output logic                         o_deviates
);
    import ptpd_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int D    = C + 1;              // coordinate differences
    localparam int LW   = 2 * C + 1;          // squared segment length
    localparam int DW   = 2 * C + 2;          // signed dot product
    localparam int BEST = 2 * C + 2;          // squared distance
    localparam int DIST = C + 1;              // distance
    localparam int MW   = (D > FRAC_BITS + 2) ? D : FRAC_BITS + 2;
    localparam int PW   = 2 * MW;
    localparam int PQ   = FRAC_BITS + C + 1;
    localparam int CW   = $clog2(FRAC_BITS + 1);
    localparam int JW   = 4 * C + 1;

    localparam logic [PQ-1:0]        ROUND   = PQ'((1 << FRAC_BITS) - 1);
    localparam logic [FRAC_BITS:0]   T_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [BEST-1:0]      BIT_TOP = {2'b01, {(BEST - 2){1'b0}}};

    t_back_state r_state;
    t_back_state n_state;

    logic signed [C-1:0]  job_ax;
    logic signed [C-1:0]  job_ay;
    logic signed [C-1:0]  job_bx;
    logic signed [C-1:0]  job_by;
    logic                 job_last;

    logic signed [D-1:0]  r_dx;
    logic signed [D-1:0]  r_dy;
    logic signed [D-1:0]  r_wx;
    logic signed [D-1:0]  r_wy;
    logic signed [D-1:0]  r_ex;
    logic signed [D-1:0]  r_ey;
    logic                 r_last;
    logic [LW-1:0]        r_len;
    logic signed [DW-1:0] r_dot;
    logic [LW-1:0]        r_rem;
    logic [FRAC_BITS:0]   r_t;
    logic [CW-1:0]        r_cnt;
    logic signed [PW-1:0] r_prod;
    logic [BEST-1:0]      r_acc;
    logic [BEST-1:0]      r_best;
    logic [BEST-1:0]      r_sv;
    logic [BEST-1:0]      r_res;
    logic [BEST-1:0]      r_bit;
    logic                 r_out_valid;
    logic [DIST-1:0]      r_distance;
    logic                 r_deviates;

    logic signed [MW-1:0] m_a;
    logic signed [MW-1:0] m_b;
    logic [D-1:0]         mag_dx;
    logic [D-1:0]         mag_dy;
    logic                 dot_pos;
    logic                 need_div;
    logic [LW:0]          rem2;
    logic                 rem_ge;
    logic [BEST-1:0]      d2;
    logic [BEST-1:0]      d2_min;
    logic [BEST-1:0]      sq_sum;
    logic                 out_free;

    // Error of one axis after projection: w - floor(t * d / 2^FRAC_BITS),
    // where p holds t * |d|.
    function automatic logic signed [D-1:0] f_err(
        input logic signed [D-1:0]  w,
        input logic signed [D-1:0]  d,
        input logic signed [PW-1:0] p
    );
        logic [PQ-1:0] pq;
        logic [PQ-1:0] rnd;
        logic [D-1:0]  off;
        pq  = p[PQ-1:0];
        rnd = d[D-1] ? pq + ROUND : pq;
        off = D'(rnd >> FRAC_BITS);
        f_err = d[D-1] ? w + $signed(off) : w - $signed(off);
    endfunction

    // Job fields from the queue head.
    always_comb begin
        job_ax   = i_job[JW-1 -: C];
        job_ay   = i_job[JW-1-C -: C];
        job_bx   = i_job[JW-1-2*C -: C];
        job_by   = i_job[C:1];
        job_last = i_job[0];
    end

    // Projection classification, divider step and minimum.
    always_comb begin
        mag_dx   = r_dx[D-1] ? D'(-r_dx) : D'(r_dx);
        mag_dy   = r_dy[D-1] ? D'(-r_dy) : D'(r_dy);
        dot_pos  = !r_dot[DW-1] && (r_dot != '0);
        need_div = (r_len != '0) && dot_pos && (r_dot[LW-1:0] < r_len);
        rem2     = {r_rem, 1'b0};
        rem_ge   = (rem2 >= {1'b0, r_len});
        d2       = r_acc + BEST'(r_prod);
        d2_min   = (d2 < r_best) ? d2 : r_best;
        sq_sum   = r_res + r_bit;
        out_free = !r_out_valid || !i_out_stall;
    end

    // Operand select of the shared multiplier.
    always_comb begin
        unique case (r_state)
            S_MUL_DXX: begin
                m_a = MW'(r_dx);
                m_b = MW'(r_dx);
            end
            S_MUL_DYY: begin
                m_a = MW'(r_dy);
                m_b = MW'(r_dy);
            end
            S_MUL_WXD: begin
                m_a = MW'(r_wx);
                m_b = MW'(r_dx);
            end
            S_MUL_WYD: begin
                m_a = MW'(r_wy);
                m_b = MW'(r_dy);
            end
            S_MUL_PX: begin
                m_a = MW'(r_t);
                m_b = MW'(mag_dx);
            end
            S_MUL_PY: begin
                m_a = MW'(r_t);
                m_b = MW'(mag_dy);
            end
            S_MUL_EXX: begin
                m_a = MW'(r_ex);
                m_b = MW'(r_ex);
            end
            S_MUL_EYY: begin
                m_a = MW'(r_ey);
                m_b = MW'(r_ey);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    // Next state and handshake outputs.
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_state = S_MUL_DXX;
                end
            end
            S_MUL_DXX:  n_state = S_MUL_DYY;
            S_MUL_DYY:  n_state = S_MUL_WXD;
            S_MUL_WXD:  n_state = S_MUL_WYD;
            S_MUL_WYD:  n_state = S_DOT_SUM;
            S_DOT_SUM:  n_state = S_CLASSIFY;
            S_CLASSIFY: n_state = need_div ? S_DIV : S_MUL_PX;
            S_DIV: begin
                if (r_cnt == CW'(1)) begin
                    n_state = S_MUL_PX;
                end
            end
            S_MUL_PX:   n_state = S_MUL_PY;
            S_MUL_PY:   n_state = S_ERR_Y;
            S_ERR_Y:    n_state = S_MUL_EXX;
            S_MUL_EXX:  n_state = S_MUL_EYY;
            S_MUL_EYY:  n_state = S_SUM;
            S_SUM:      n_state = r_last ? S_SQRT : S_IDLE;
            S_SQRT: begin
                if (r_bit[0]) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath: multiplier register and the per-state updates.
    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        unique case (r_state)
            S_IDLE: begin
                r_dx   <= D'(job_bx) - D'(job_ax);
                r_dy   <= D'(job_by) - D'(job_ay);
                r_wx   <= D'(i_query_x) - D'(job_ax);
                r_wy   <= D'(i_query_y) - D'(job_ay);
                r_last <= job_last;
            end
            S_MUL_DYY: r_len <= LW'(r_prod);
            S_MUL_WXD: r_len <= r_len + LW'(r_prod);
            S_MUL_WYD: r_dot <= DW'(r_prod);
            S_DOT_SUM: r_dot <= r_dot + DW'(r_prod);
            S_CLASSIFY: begin
                // Clamp below, clamp above or divide.
                r_rem <= r_dot[LW-1:0];
                r_cnt <= CW'(FRAC_BITS);
                if ((r_len == '0) || !dot_pos || need_div) begin
                    r_t <= '0;
                end else begin
                    r_t <= T_ONE;
                end
            end
            S_DIV: begin
                // One quotient bit a cycle.
                r_rem <= rem_ge ? LW'(rem2 - {1'b0, r_len}) : LW'(rem2);
                r_t   <= {r_t[FRAC_BITS-1:0], rem_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            S_MUL_PY: r_ex <= f_err(r_wx, r_dx, r_prod);
            S_ERR_Y:  r_ey <= f_err(r_wy, r_dy, r_prod);
            S_MUL_EYY: r_acc <= BEST'(r_prod);
            S_SUM: begin
                r_sv  <= d2_min;
                r_res <= '0;
                r_bit <= BIT_TOP;
            end
            S_SQRT: begin
                // One root bit a cycle.
                if (r_sv >= sq_sum) begin
                    r_sv  <= r_sv - sq_sum;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            default: begin
            end
        endcase
    end

    // Running minimum over the path; cleared once the path ends.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '1;
        end else if (r_state == S_SUM) begin
            r_best <= r_last ? '1 : d2_min;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_EMIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && out_free) begin
            r_distance <= r_res[DIST-1:0];
            r_deviates <= (r_res[DIST-1:0] > i_limit);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_distance;
    assign o_deviates  = r_deviates;

endmodule
